/* rtl/dtm_pkg.sv */
`timescale 1ns / 1ps

package dtm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_TILES_DEF  = 4096;
    localparam int VALUE_BITS_DEF = 8;

    // Field widths.
    localparam int TS_W     = 7;
    localparam int AREA_W   = 13;
    localparam int COORD_W  = 16;
    localparam int VAL_W    = 8;
    localparam int TIDX_W   = 12;
    localparam int POS_W    = 13;
    localparam int REGION_W = 13;

    // Internal datapath widths.
    localparam int DIV_N_W = 16;
    localparam int DIV_D_W = 14;
    localparam int DIM_W   = 13;
    localparam int PROD_W  = 26;

    localparam logic [REGION_W-1:0] REGION_MAX = 13'h1FFF;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_TILE_SIZE   = 2'd0;
    localparam logic [1:0] REG_AREA_WIDTH  = 2'd1;
    localparam logic [1:0] REG_AREA_HEIGHT = 2'd2;

    // Command codes.
    localparam logic [1:0] MODE_MARK   = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_LOCATE = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [VAL_W-1:0]          value_in;
        logic [TIDX_W-1:0]         tile_index;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0]    read_value;
        logic [POS_W-1:0]    tile_left;
        logic [POS_W-1:0]    tile_top;
        logic [TS_W-1:0]     tile_extent;
        logic [TIDX_W-1:0]   index_out;
        logic [REGION_W-1:0] region_count;
        logic                status;
    } out_t;

    typedef struct packed {
        logic [TS_W-1:0]   tile_size;
        logic [AREA_W-1:0] area_width;
        logic [AREA_W-1:0] area_height;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACROSS,
        ST_DOWN,
        ST_COUNT,
        ST_CHECK,
        ST_SPAN_X,
        ST_MOD_X,
        ST_DIV_X,
        ST_SPAN_Y,
        ST_MOD_Y,
        ST_DIV_Y,
        ST_INDEX_MUL,
        ST_INDEX_WR,
        ST_CLEAR,
        ST_READ_WAIT,
        ST_LOC_DIV,
        ST_LOC_LEFT,
        ST_LOC_TOP,
        ST_DONE
    } ctrl_state_t;

endpackage

/* rtl/dtm_divider.sv */
`timescale 1ns / 1ps

module dtm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  dtm_pkg::div_req_t req,
    output dtm_pkg::div_rsp_t rsp
);
    import dtm_pkg::*;

    localparam int ITER_W = $clog2(DIV_N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dsr_reg, dsr_next;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // One restoring step per cycle: the dividend shifts out of the quotient
    // register into the partial remainder while quotient bits shift in.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_N_W-1]};
        fits      = shifted >= {1'b0, dsr_reg};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(DIV_N_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            rem_next = fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            iter_next = iter_reg - 1'b1;
            if (iter_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/dtm_tile_store.sv */
`timescale 1ns / 1ps

module dtm_tile_store #(
    parameter int DEPTH   = dtm_pkg::MAX_TILES_DEF,
    parameter int VALUE_W = dtm_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [VALUE_W-1:0] rdata
);
    import dtm_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dtm_ctrl.sv */
`timescale 1ns / 1ps

module dtm_ctrl #(
    parameter int MAX_TILES  = dtm_pkg::MAX_TILES_DEF,
    parameter int VALUE_BITS = dtm_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtm_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    input  dtm_pkg::in_t          in_data,
    output logic                  in_stall,
    output logic                  res_valid,
    output dtm_pkg::out_t         res_data,
    input  logic                  res_take,
    output dtm_pkg::div_req_t     div_req,
    input  dtm_pkg::div_rsp_t     div_rsp,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [ADDR_W-1:0]     mem_raddr,
    input  logic [VALUE_BITS-1:0] mem_rdata
);
    import dtm_pkg::*;

    localparam int CTR_W = ADDR_W + 1;

    ctrl_state_t         state_reg, state_next;

    in_t                 in_reg, in_next;
    logic [DIM_W-1:0]    across_reg, across_next;
    logic [DIM_W-1:0]    down_reg, down_next;
    logic [PROD_W-1:0]   count_reg, count_next;
    logic [DIV_D_W-1:0]  span_reg, span_next;
    logic [DIM_W-1:0]    qx_reg, qx_next;
    logic [DIM_W-1:0]    qy_reg, qy_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CTR_W-1:0]    ctr_reg, ctr_next;
    logic [VAL_W-1:0]    rv_reg, rv_next;
    logic [POS_W-1:0]    left_reg, left_next;
    logic [POS_W-1:0]    top_reg, top_next;
    logic [TIDX_W-1:0]   idx_reg, idx_next;
    logic                status_reg, status_next;

    logic [DIM_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [COORD_W-1:0]  abs_x, abs_y;
    logic                neg_sel;
    logic [DIV_D_W-1:0]  wrapped;
    logic [PROD_W-1:0]   idx_sum;
    logic [CTR_W-1:0]    ctr_inc;
    logic [DIM_W-1:0]    ts_ext;

    assign ts_ext = DIM_W'(cfg.tile_size);

    // The one multiplier, shared by every step that needs a product.
    always_comb
    begin
        case (state_reg)
            ST_COUNT:
            begin
                mul_a = across_reg;
                mul_b = down_reg;
            end
            ST_SPAN_X:
            begin
                mul_a = across_reg;
                mul_b = ts_ext;
            end
            ST_SPAN_Y:
            begin
                mul_a = down_reg;
                mul_b = ts_ext;
            end
            ST_INDEX_MUL:
            begin
                mul_a = qy_reg;
                mul_b = across_reg;
            end
            ST_LOC_LEFT:
            begin
                mul_a = qx_reg;
                mul_b = ts_ext;
            end
            ST_LOC_TOP:
            begin
                mul_a = qy_reg;
                mul_b = ts_ext;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // The divider works on magnitudes; a negative coordinate folds back by
    // taking the remainder from the span when it is not zero.
    always_comb
    begin
        abs_x = in_reg.coord_x[COORD_W-1] ? COORD_W'(~in_reg.coord_x) + 1'b1
                                          : COORD_W'(in_reg.coord_x);
        abs_y = in_reg.coord_y[COORD_W-1] ? COORD_W'(~in_reg.coord_y) + 1'b1
                                          : COORD_W'(in_reg.coord_y);
        neg_sel = (state_reg == ST_MOD_Y) ? in_reg.coord_y[COORD_W-1]
                                          : in_reg.coord_x[COORD_W-1];
        wrapped = (neg_sel && div_rsp.remainder != '0) ? span_reg - div_rsp.remainder
                                                       : div_rsp.remainder;
        idx_sum = prod_reg + PROD_W'(qx_reg);
        ctr_inc = ctr_reg + 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_next     = in_reg;
        across_next = across_reg;
        down_next   = down_reg;
        count_next  = count_reg;
        span_next   = span_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        prod_next   = prod_reg;
        ctr_next    = ctr_reg;
        rv_next     = rv_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        idx_next    = idx_reg;
        status_next = status_reg;

        div_req     = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = VALUE_BITS'(in_reg.value_in);
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(in_reg.tile_index);

        in_stall    = state_reg != ST_IDLE;
        res_valid   = state_reg == ST_DONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next     = in_data;
                    count_next  = '0;
                    rv_next     = '0;
                    left_next   = '0;
                    top_next    = '0;
                    idx_next    = '0;
                    status_next = 1'b0;
                    if (cfg.tile_size == '0)
                    begin
                        status_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_N_W'(cfg.area_width)
                                         + DIV_N_W'(cfg.tile_size) - 1'b1;
                        div_req.divisor  = DIV_D_W'(cfg.tile_size);
                        state_next       = ST_ACROSS;
                    end
                end
            end
            ST_ACROSS:
            begin
                if (div_rsp.done)
                begin
                    across_next      = DIM_W'(div_rsp.quotient);
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'(cfg.area_height)
                                     + DIV_N_W'(cfg.tile_size) - 1'b1;
                    div_req.divisor  = DIV_D_W'(cfg.tile_size);
                    state_next       = ST_DOWN;
                end
            end
            ST_DOWN:
            begin
                if (div_rsp.done)
                begin
                    down_next  = DIM_W'(div_rsp.quotient);
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                count_next = prod;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (count_reg == '0 || count_reg > PROD_W'(MAX_TILES))
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    case (in_reg.mode)
                        MODE_MARK:
                        begin
                            state_next = ST_SPAN_X;
                        end
                        MODE_CLEAR:
                        begin
                            ctr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            idx_next = in_reg.tile_index;
                            if (PROD_W'(in_reg.tile_index) >= count_reg)
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else if (in_reg.mode == MODE_READ)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_READ_WAIT;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_N_W'(in_reg.tile_index);
                                div_req.divisor  = DIV_D_W'(across_reg);
                                state_next       = ST_LOC_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_SPAN_X:
            begin
                span_next        = DIV_D_W'(prod);
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(abs_x);
                div_req.divisor  = DIV_D_W'(prod);
                state_next       = ST_MOD_X;
            end
            ST_MOD_X:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'(wrapped);
                    div_req.divisor  = DIV_D_W'(cfg.tile_size);
                    state_next       = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    qx_next    = DIM_W'(div_rsp.quotient);
                    state_next = ST_SPAN_Y;
                end
            end
            ST_SPAN_Y:
            begin
                span_next        = DIV_D_W'(prod);
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(abs_y);
                div_req.divisor  = DIV_D_W'(prod);
                state_next       = ST_MOD_Y;
            end
            ST_MOD_Y:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'(wrapped);
                    div_req.divisor  = DIV_D_W'(cfg.tile_size);
                    state_next       = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    qy_next    = DIM_W'(div_rsp.quotient);
                    state_next = ST_INDEX_MUL;
                end
            end
            ST_INDEX_MUL:
            begin
                prod_next  = prod;
                state_next = ST_INDEX_WR;
            end
            ST_INDEX_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(idx_sum);
                idx_next   = idx_sum[TIDX_W-1:0];
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ctr_reg[ADDR_W-1:0];
                ctr_next  = ctr_inc;
                if (ctr_inc == CTR_W'(count_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT:
            begin
                rv_next    = VAL_W'(mem_rdata);
                state_next = ST_DONE;
            end
            ST_LOC_DIV:
            begin
                if (div_rsp.done)
                begin
                    qx_next    = DIM_W'(div_rsp.remainder);
                    qy_next    = DIM_W'(div_rsp.quotient);
                    state_next = ST_LOC_LEFT;
                end
            end
            ST_LOC_LEFT:
            begin
                left_next  = prod[POS_W-1:0];
                state_next = ST_LOC_TOP;
            end
            ST_LOC_TOP:
            begin
                top_next   = prod[POS_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        across_reg <= across_next;
        down_reg   <= down_next;
        count_reg  <= count_next;
        span_reg   <= span_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        prod_reg   <= prod_next;
        ctr_reg    <= ctr_next;
        rv_reg     <= rv_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        res_data.read_value   = rv_reg;
        res_data.tile_left    = left_reg;
        res_data.tile_top     = top_reg;
        res_data.tile_extent  = cfg.tile_size;
        res_data.index_out    = idx_reg;
        res_data.region_count = (count_reg > PROD_W'(REGION_MAX)) ? REGION_MAX
                                                                  : count_reg[REGION_W-1:0];
        res_data.status       = status_reg;
    end

endmodule

/* rtl/dirty_tile_map.sv */
`timescale 1ns / 1ps

// Tile map over a 2D pixel area: each command (mark, clear, read, locate)
// gives one result transaction. Commands are taken one at a time. Every
// command with a nonzero tile size first derives the tile grid with two
// divisions on one shared restoring divider of 16 steps. A mark uses six
// divisions in all, and a clear writes the tiles one after another, since
// the tile store has a single write port. A finished result waits in the
// output register while the next command is accepted. Configuration
// registers sit at byte addresses 0 (tile size), 4 (area width) and 8
// (area height).
module dirty_tile_map #(
    parameter int MAX_TILES  = dtm_pkg::MAX_TILES_DEF,
    parameter int VALUE_BITS = dtm_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dtm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dtm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dtm_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dtm_pkg::out_t                  out_data
);
    import dtm_pkg::*;

    localparam int ADDR_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

    logic [TS_W-1:0]   ts_reg;
    logic [AREA_W-1:0] aw_reg;
    logic [AREA_W-1:0] ah_reg;
    cfg_t              cfg;

    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg;

    logic              res_valid;
    out_t              res_data;
    logic              res_take;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= TS_W'(8);
            aw_reg <= AREA_W'(400);
            ah_reg <= AREA_W'(300);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_TILE_SIZE:   ts_reg <= pwdata[TS_W-1:0];
                REG_AREA_WIDTH:  aw_reg <= pwdata[AREA_W-1:0];
                REG_AREA_HEIGHT: ah_reg <= pwdata[AREA_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TILE_SIZE:   prdata = APB_DATA_W'(ts_reg);
            REG_AREA_WIDTH:  prdata = APB_DATA_W'(aw_reg);
            REG_AREA_HEIGHT: prdata = APB_DATA_W'(ah_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.tile_size   = ts_reg;
    assign cfg.area_width  = aw_reg;
    assign cfg.area_height = ah_reg;

    dtm_ctrl #(
        .MAX_TILES  (MAX_TILES),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_take  (res_take),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dtm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dtm_tile_store #(
        .DEPTH   (MAX_TILES),
        .VALUE_W (VALUE_BITS),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a result whenever it is empty or its
    // current transaction completes in this cycle.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/dtm_checker.sv */
`timescale 1ns / 1ps

module dtm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input dtm_pkg::out_t out_data
);
    import dtm_pkg::*;

    // A held result must not change while it waits.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Commands are worked one at a time, so the input closes after a transaction.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // A good result always names a tile inside the grid.
    a_index_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.status |->
            REGION_W'(out_data.index_out) < out_data.region_count)
        else $error("good result with index outside the grid");

    // A good result implies a real tile size.
    a_extent_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.status |-> out_data.tile_extent != '0)
        else $error("good result with zero tile size");

endmodule

bind dirty_tile_map dtm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
